FILE: rtl/pfd_pkg.sv
// Shared constants, codes and control types for the pressure frame deframer.
package pfd_pkg;

  // Frame marker bytes
  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] END_MARK   = 8'h00;
  localparam logic [7:0] TYPE_MARK  = 8'h08;

  // Byte offsets inside a frame
  localparam int OFS_TYPE  = 3;
  localparam int OFS_ID_HI = 6;
  localparam int OFS_ID_LO = 7;
  localparam int OFS_CHAN  = 8;
  localparam int OFS_V_HI  = 9;
  localparam int OFS_V_LO  = 10;

  // Conversion: SCALE_NUM / (v + 1) - SCALE_OFS
  localparam int          DIV_BITS  = 22;
  localparam int          DIV_CNT_W = 5;
  localparam logic [21:0] SCALE_NUM = 22'd4000000;
  localparam logic [22:0] SCALE_OFS = 23'd1000;

  // Register map
  localparam int          CFG_ADDR_W      = 3;
  localparam logic [0:0]  REG_EXPECTED_ID = 1'b0;
  localparam logic [15:0] ID_RESET        = 16'd2027;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } pfd_state_t;

  // Controller to datapath
  typedef struct packed {
    logic push;       // append accepted word to the window
    logic drop;       // bad end: drop start word, shift in accepted word
    logic clear;      // empty the window
    logic shift;      // drop head word while rescanning
    logic div_start;  // latch frame fields, start divide, empty window
    logic div_step;   // one quotient bit
    logic load_out;   // move result into the output register
  } pfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;       // window holds a frame minus its last word
    logic byte_end;   // input word is the end mark
    logic frame_ok;   // type, id and channel checks pass
    logic scan_done;  // window empty or head is a start mark
    logic div_last;   // current divide step is the last
    logic out_full;   // output register still holds a word
  } pfd_stat_t;

endpackage

FILE: rtl/pfd_in_if.sv
// Input byte channel: valid/ready handshake with one received byte.
interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/pfd_out_if.sv
// Result channel: valid/ready handshake with channel and converted pressure.
interface pfd_out_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  channel;
  logic signed [22:0] pressure_value;

  modport source (output valid, output channel, output pressure_value, input ready);
  modport sink   (input valid, input channel, input pressure_value, output ready);
endinterface

FILE: rtl/pressure_frame_deframer.sv
// Pressure frame deframer top level: channels, register port, controller and datapath.
//
// Takes one received byte per word on in_ch and finds frames that start with 0xAA and
// end with 0x00; a frame whose type, id and channel check out yields one word on out_ch
// with the channel and 4000000/(v+1)-1000. Bytes are taken one per cycle while a frame
// is being gathered. When a frame passes its checks, the input stalls while the
// one-bit-per-cycle restoring divider runs and the output register is loaded; the
// load waits while that register holds an untaken word. When a candidate has a bad
// end byte, the window is rescanned one byte per cycle for the next start mark while
// the input stalls. expected_id is at APB byte addresses 0 to 3, reset 2027.
module pressure_frame_deframer import pfd_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int CHANNELS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfd_in_if.sink                in_ch,
  pfd_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [15:0] expected_id_r;
  pfd_cmd_t    cmd;
  pfd_stat_t   stat;
  logic        reg_sel;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:CFG_ADDR_W-1] == REG_EXPECTED_ID);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_id_r <= ID_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      expected_id_r <= pwdata[15:0];
    end
  end

  assign prdata = reg_sel ? {16'd0, expected_id_r} : 32'd0;

  // Controller
  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  // Datapath
  pfd_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rx_byte        (in_ch.rx_byte),
    .expected_id    (expected_id_r),
    .out_ready      (out_ch.ready),
    .stat           (stat),
    .out_valid      (out_ch.valid),
    .channel        (out_ch.channel),
    .pressure_value (out_ch.pressure_value)
  );

endmodule

FILE: rtl/pfd_ctrl.sv
// Deframer controller: sequences byte intake, rescans and the divide.
module pfd_ctrl import pfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  pfd_stat_t stat,
  output logic      in_ready,
  output pfd_cmd_t  cmd
);

  pfd_state_t state_r;
  pfd_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (!stat.full) begin
            cmd.push = 1'b1;
          end else if (!stat.byte_end) begin
            cmd.drop  = 1'b1;
            state_nxt = ST_SCAN;
          end else if (stat.frame_ok) begin
            cmd.div_start = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            cmd.clear = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // drop words until a start mark heads the window or the window is empty
        if (stat.scan_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // The divide always runs its full length before the result is handed over
  a_div_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && stat.div_last) |=> (state_r == ST_DONE))
    else $error("divide did not finish into the done state");
`endif

endmodule

FILE: rtl/pfd_dp.sv
// Deframer datapath: byte window, frame checks, serial divider, output register.
module pfd_dp import pfd_pkg::*; #(
  parameter int FRAME_BYTES = 16,
  parameter int CHANNELS    = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pfd_cmd_t           cmd,
  input  logic        [7:0]  rx_byte,
  input  logic        [15:0] expected_id,
  input  logic               out_ready,
  output pfd_stat_t          stat,
  output logic               out_valid,
  output logic        [3:0]  channel,
  output logic signed [22:0] pressure_value
);

  localparam int W  = FRAME_BYTES - 1;
  localparam int FW = $clog2(FRAME_BYTES);

  logic [7:0]    win_r [W];
  logic [FW-1:0] fill_r;

  logic [16:0]          d_r;
  logic [16:0]          rem_r;
  logic [DIV_BITS-1:0]  q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [3:0]           chan_r;

  logic               out_valid_r;
  logic        [3:0]  out_chan_r;
  logic signed [22:0] out_p_r;

  logic [17:0] trial;
  logic [17:0] trial_diff;
  logic        trial_lt;

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      priority if (cmd.clear || cmd.div_start) begin
        fill_r <= '0;
      end else if (cmd.push) begin
        if (fill_r != '0 || rx_byte == START_MARK) begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (cmd.shift) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Window words: written at the fill point, or shifted down by one
  for (genvar i = 0; i < W; i++) begin : g_win
    always_ff @(posedge clk) begin
      if (cmd.push && fill_r == FW'(i)) begin
        win_r[i] <= rx_byte;
      end else if (cmd.drop || cmd.shift) begin
        if (i < W - 1) begin
          win_r[i] <= win_r[(i < W - 1) ? i + 1 : i];
        end else if (cmd.drop) begin
          win_r[i] <= rx_byte;
        end
      end
    end
  end

  // Status
  always_comb begin
    stat.full      = (fill_r == FW'(W));
    stat.byte_end  = (rx_byte == END_MARK);
    stat.frame_ok  = (win_r[OFS_TYPE] == TYPE_MARK) &&
                     ({win_r[OFS_ID_HI], win_r[OFS_ID_LO]} == expected_id) &&
                     ({1'b0, win_r[OFS_CHAN]} < 9'(CHANNELS));
    stat.scan_done = (fill_r == '0) || (win_r[0] == START_MARK);
    stat.div_last  = (cnt_r == DIV_CNT_W'(DIV_BITS - 1));
    stat.out_full  = out_valid_r;
  end

  // Restoring divide step, one quotient bit per cycle
  assign trial      = {rem_r, q_r[DIV_BITS-1]};
  assign trial_lt   = (trial < {1'b0, d_r});
  assign trial_diff = trial - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      d_r    <= 17'({win_r[OFS_V_HI], win_r[OFS_V_LO]}) + 17'd1;
      rem_r  <= '0;
      q_r    <= SCALE_NUM;
      cnt_r  <= '0;
      chan_r <= win_r[OFS_CHAN][3:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_lt ? trial[16:0] : trial_diff[16:0];
      q_r   <= {q_r[DIV_BITS-2:0], ~trial_lt};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_chan_r <= chan_r;
      out_p_r    <= signed'({1'b0, q_r} - SCALE_OFS);
    end
  end

  assign out_valid      = out_valid_r;
  assign channel        = out_chan_r;
  assign pressure_value = out_p_r;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(W))
    else $error("window fill beyond capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r)
    else $error("result loaded over a pending word");

  a_frame_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (fill_r == '0))
    else $error("accepted frame left bytes in the window");
`endif

endmodule
